[rtl/prrp_pkg.sv]
// ----------------------------------------------------------------------------
// prrp_pkg
// shared types and constants for the priority round-robin region picker
// ----------------------------------------------------------------------------
package prrp_pkg;

	localparam int MAX_REGIONS = 16;
	localparam int IDX_W       = $clog2(MAX_REGIONS);
	localparam int CNT_W       = $clog2(MAX_REGIONS + 1);

	localparam int FIELD_IDX_W  = 4;
	localparam int PASS_W       = 16;
	localparam int PRIO_W       = 8;
	localparam int PREV_W       = 5;
	localparam int RCOUNT_W     = 5;

	localparam int IN_DATA_W    = 56;
	localparam int OUT_DATA_W   = 8;

	localparam int QUEUE_DEPTH  = 4;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

	localparam logic [PASS_W-1:0] TARGET_RESET = PASS_W'(1);
	localparam logic [PRIO_W-1:0] PRIO_RESET   = PRIO_W'(10);

	localparam logic KIND_WRITE  = 1'b0;
	localparam logic KIND_SELECT = 1'b1;

	typedef struct packed {
		logic                   is_select;
		logic [FIELD_IDX_W-1:0] entry_index;
		logic                   entry_enabled;
		logic [PASS_W-1:0]      target_passes;
		logic [PASS_W-1:0]      done_passes;
		logic [PRIO_W-1:0]      entry_priority;
		logic                   prev_negative;
		logic [FIELD_IDX_W-1:0] prev_low;
		logic                   skip_valid;
		logic [FIELD_IDX_W-1:0] skip_index;
	} cmd_t;

	typedef struct packed {
		logic not_empty;
	} queue_ctl_t;

endpackage

[rtl/prrp_front.sv]
// ----------------------------------------------------------------------------
// prrp_front
// accepts input items, classifies and unpacks them into a short command queue
// ----------------------------------------------------------------------------
module prrp_front
	import prrp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// entry_index, entry_enabled, target_passes, done_passes, entry_priority,
	// prev_index, skip_valid, skip_index, zero pad
	input  logic [IN_DATA_W-1:0] s_axis_tdata,
	// kind
	input  logic                 s_axis_tuser,
	input  logic                 pop,
	output queue_ctl_t           status,
	output cmd_t                 head
);

	cmd_t               q_mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	logic               push;
	logic               do_pop;
	logic [PREV_W-1:0]  prev_raw;
	cmd_t               cmd_in;

	assign s_axis_tready = (32'(count_q) < QUEUE_DEPTH);
	assign push          = s_axis_tvalid & s_axis_tready;
	assign do_pop        = pop & (count_q != '0);
	assign prev_raw      = s_axis_tdata[49:45];

	// classify the item and split the payload
	always_comb begin
		cmd_in.is_select      = (s_axis_tuser == KIND_SELECT);
		cmd_in.entry_index    = s_axis_tdata[3:0];
		cmd_in.entry_enabled  = s_axis_tdata[4];
		cmd_in.target_passes  = s_axis_tdata[20:5];
		cmd_in.done_passes    = s_axis_tdata[36:21];
		cmd_in.entry_priority = s_axis_tdata[44:37];
		cmd_in.prev_negative  = prev_raw[PREV_W-1];
		cmd_in.prev_low       = prev_raw[FIELD_IDX_W-1:0];
		cmd_in.skip_valid     = s_axis_tdata[50];
		cmd_in.skip_index     = s_axis_tdata[54:51];
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			unique case ({push, do_pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	assign head             = q_mem_q[rd_ptr_q];
	assign status.not_empty = (count_q != '0);

endmodule

[rtl/prrp_back.sv]
// ----------------------------------------------------------------------------
// prrp_back
// region table, two-pass priority and round-robin scanner, result register
// ----------------------------------------------------------------------------
module prrp_back
	import prrp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [RCOUNT_W-1:0]   region_count,
	input  queue_ctl_t            status,
	input  cmd_t                  head,
	output logic                  pop,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// chosen_index, zero pad
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	// found
	output logic                  m_axis_tuser
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN1  = 2'd1;
	localparam logic [1:0] ST_SCAN2  = 2'd2;
	localparam logic [1:0] ST_RESULT = 2'd3;

	logic                   en_q     [MAX_REGIONS];
	logic [PASS_W-1:0]      target_q [MAX_REGIONS];
	logic [PASS_W-1:0]      done_q   [MAX_REGIONS];
	logic [PRIO_W-1:0]      prio_q   [MAX_REGIONS];

	logic [1:0]             state_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   prev_neg_q;
	logic [FIELD_IDX_W-1:0] prev_low_q;
	logic                   skip_valid_q;
	logic [FIELD_IDX_W-1:0] skip_index_q;
	logic                   any_q;
	logic [PRIO_W-1:0]      best_q;
	logic                   have_first_q;
	logic                   have_next_q;
	logic [IDX_W-1:0]       first_q;
	logic [IDX_W-1:0]       next_q;
	logic                   out_valid_q;
	logic                   out_found_q;
	logic [FIELD_IDX_W-1:0] out_index_q;

	logic [CNT_W-1:0]       limit;
	logic [IDX_W-1:0]       idx;
	logic                   elig;
	logic                   above_prev;
	logic                   out_free;
	logic                   take_write;
	logic                   take_select;
	logic                   load_result;
	logic [IDX_W-1:0]       pick;

	assign limit = (32'(region_count) > MAX_REGIONS) ? CNT_W'(MAX_REGIONS) : CNT_W'(region_count);
	assign idx   = cnt_q[IDX_W-1:0];

	assign elig = en_q[idx] && (done_q[idx] < target_q[idx])
		&& !(skip_valid_q && (32'(idx) == 32'(skip_index_q)));
	assign above_prev = prev_neg_q || (32'(idx) > 32'(prev_low_q));

	assign out_free    = !out_valid_q || m_axis_tready;
	assign take_write  = (state_q == ST_IDLE) && status.not_empty && !head.is_select && out_free;
	assign take_select = (state_q == ST_IDLE) && status.not_empty && head.is_select;
	assign pop         = take_write || take_select;
	assign load_result = (state_q == ST_RESULT) && out_free;
	assign pick        = have_next_q ? next_q : first_q;

	// region table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_REGIONS; i++) begin
				en_q[i]     <= 1'b0;
				target_q[i] <= TARGET_RESET;
				done_q[i]   <= '0;
				prio_q[i]   <= PRIO_RESET;
			end
		end else if (take_write && (32'(head.entry_index) < MAX_REGIONS)) begin
			en_q[IDX_W'(head.entry_index)]     <= head.entry_enabled;
			target_q[IDX_W'(head.entry_index)] <= head.target_passes;
			done_q[IDX_W'(head.entry_index)]   <= head.done_passes;
			prio_q[IDX_W'(head.entry_index)]   <= head.entry_priority;
		end
	end

	// select request fields
	always_ff @(posedge clk) begin
		if (take_select) begin
			prev_neg_q   <= head.prev_negative;
			prev_low_q   <= head.prev_low;
			skip_valid_q <= head.skip_valid;
			skip_index_q <= head.skip_index;
		end
	end

	// scanner
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			any_q        <= 1'b0;
			best_q       <= '0;
			have_first_q <= 1'b0;
			have_next_q  <= 1'b0;
			first_q      <= '0;
			next_q       <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (take_select) begin
						state_q      <= ST_SCAN1;
						cnt_q        <= '0;
						any_q        <= 1'b0;
						have_first_q <= 1'b0;
						have_next_q  <= 1'b0;
					end
				end
				ST_SCAN1: begin
					if (cnt_q == limit) begin
						cnt_q   <= '0;
						state_q <= any_q ? ST_SCAN2 : ST_RESULT;
					end else begin
						if (elig && (!any_q || (prio_q[idx] < best_q))) begin
							best_q <= prio_q[idx];
						end
						if (elig) begin
							any_q <= 1'b1;
						end
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				ST_SCAN2: begin
					if (cnt_q == limit) begin
						state_q <= ST_RESULT;
					end else begin
						if (elig && (prio_q[idx] == best_q)) begin
							if (!have_first_q) begin
								have_first_q <= 1'b1;
								first_q      <= idx;
							end
							if (!have_next_q && above_prev) begin
								have_next_q <= 1'b1;
								next_q      <= idx;
							end
						end
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				ST_RESULT: begin
					if (load_result) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take_write || load_result) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_write) begin
			out_found_q <= 1'b0;
			out_index_q <= '0;
		end else if (load_result) begin
			out_found_q <= any_q;
			out_index_q <= any_q ? FIELD_IDX_W'(pick) : '0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_found_q;
	assign m_axis_tdata  = OUT_DATA_W'(out_index_q);

endmodule

[rtl/priority_round_robin_region_picker_unit.sv]
// ----------------------------------------------------------------------------
// priority_round_robin_region_picker_unit
// picks the next scan region by least priority, then round robin by index
// ----------------------------------------------------------------------------
// A write item (kind 0) stores one region entry in the back end. A select
// item (kind 1) runs up to two passes over the table, one entry per cycle:
// the first finds the least priority among eligible regions, and the second,
// run only when some region is eligible, picks the lowest index above
// prev_index at that priority, wrapping to the lowest. Each pass walks
// n = min(region_count, 16) entries. A four-item command queue lets input
// items arrive while a scan runs, and each item gives exactly one result.
// region_count must be written over the cfg channel only while the block is
// idle; the block itself does not enforce this.
module priority_round_robin_region_picker_unit
	import prrp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [RCOUNT_W-1:0]   cfg_data,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// entry_index, entry_enabled, target_passes, done_passes, entry_priority,
	// prev_index, skip_valid, skip_index, zero pad
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// kind
	input  logic                  s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// chosen_index, zero pad
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	// found
	output logic                  m_axis_tuser
);

	logic [RCOUNT_W-1:0] region_count_q;
	queue_ctl_t          status;
	cmd_t                head;
	logic                pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_count_q <= '0;
		end else if (cfg_valid) begin
			region_count_q <= cfg_data;
		end
	end

	prrp_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.pop           (pop),
		.status        (status),
		.head          (head)
	);

	prrp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.region_count  (region_count_q),
		.status        (status),
		.head          (head),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule
